// ===== hdl/priority_task_table_with_retry_assert.svh =====
// ----------------------------------------------------------------------------
// priority task table assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TASK_TABLE_WITH_RETRY_ASSERT_SVH
`define PRIORITY_TASK_TABLE_WITH_RETRY_ASSERT_SVH

// same-cycle implication
`define PTT_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg
// shared constants, codes and types of the priority task table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptt_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// field widths
	localparam int KIND_W = 2;
	localparam int PRIO_W = 3;
	localparam int EXIT_W = 9;
	localparam int CODE_W = 3;
	localparam int ID_W   = 9;
	localparam int RET_W  = 4;

	// event kinds
	localparam logic [KIND_W-1:0] K_ADD      = 2'd0;
	localparam logic [KIND_W-1:0] K_DISPATCH = 2'd1;
	localparam logic [KIND_W-1:0] K_FINISH   = 2'd2;

	// priorities
	localparam logic [PRIO_W-1:0] PRIO_LOW  = 3'd1;
	localparam logic [PRIO_W-1:0] PRIO_MED  = 3'd2;
	localparam logic [PRIO_W-1:0] PRIO_HIGH = 3'd3;

	// entry status
	localparam logic [1:0] ST_PENDING = 2'd0;
	localparam logic [1:0] ST_RUNNING = 2'd1;
	localparam logic [1:0] ST_DONE    = 2'd2;
	localparam logic [1:0] ST_FAILED  = 2'd3;

	// result codes
	localparam logic [CODE_W-1:0] RC_ADDED      = 3'd0;
	localparam logic [CODE_W-1:0] RC_FULL       = 3'd1;
	localparam logic [CODE_W-1:0] RC_DISPATCHED = 3'd2;
	localparam logic [CODE_W-1:0] RC_NONE       = 3'd3;
	localparam logic [CODE_W-1:0] RC_COMPLETED  = 3'd4;
	localparam logic [CODE_W-1:0] RC_RETRYING   = 3'd5;
	localparam logic [CODE_W-1:0] RC_FAILED     = 3'd6;
	localparam logic [CODE_W-1:0] RC_BUSY       = 3'd7;

	localparam logic [RET_W-1:0] MAX_RETRIES_RST = 4'd2;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN
	} state_t;

	// broadcast write into the cell row
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] slot;
		logic             set_status;
		logic [1:0]       status;
		logic             set_prio;
		logic [1:0]       prio;
		logic             set_ret;
		logic [RET_W-1:0] ret;
	} wr_t;

	// best candidate travelling along the cell row
	typedef struct packed {
		logic             found;
		logic [1:0]       prio;
		logic [IDX_W-1:0] slot;
		logic [RET_W-1:0] ret;
	} cand_t;

	// slot index to task id (slot plus one, kept to the id width)
	function automatic logic [ID_W-1:0] make_id(input logic [IDX_W-1:0] slot);
		logic [IDX_W:0] sum;
		sum = {1'b0, slot} + {{IDX_W{1'b0}}, 1'b1};
		return ID_W'(sum);
	endfunction

endpackage

// ===== hdl/ptt_in_if.sv =====
// ----------------------------------------------------------------------------
// ptt_in_if
// event channel: valid, ready and one event beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptt_in_if;
	import ptt_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic [PRIO_W-1:0]        priority_req;
	logic signed [EXIT_W-1:0] exit_status;

	modport source (output valid, output kind, output priority_req, output exit_status,
		input ready);
	modport sink (input valid, input kind, input priority_req, input exit_status,
		output ready);
endinterface

// ===== hdl/ptt_out_if.sv =====
// ----------------------------------------------------------------------------
// ptt_out_if
// result channel: valid, ready and one result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptt_out_if;
	import ptt_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] result_code;
	logic [ID_W-1:0]   task_id;
	logic [RET_W-1:0]  retries_done;

	modport source (output valid, output result_code, output task_id, output retries_done,
		input ready);
	modport sink (input valid, input result_code, input task_id, input retries_done,
		output ready);
endinterface

// ===== hdl/priority_task_table_with_retry.sv =====
// ----------------------------------------------------------------------------
// priority_task_table_with_retry
// task table with static priority dispatch and bounded retries
//
//   channel  dir  handshake      beat
//   evt      in   valid/ready    kind, priority_req, exit_status
//   res      out  valid/ready    result_code, task_id, retries_done
//   cfg      in   cfg_we         cfg_wdata -> max_retries
//
// add, finish and busy dispatch: S_EXEC loads the result register once res is free
// dispatch with no task running: S_SCAN loads the result once res is free and the scan
//   candidate has walked one cell per cycle down the row of TABLE_DEPTH cells
// one event at a time; the next event is taken while a result waits in res
// a stalled res holds the finished event in its sequencer state
// reset clears fill count and running task, max_retries returns to 2;
//   table entries are not cleared and no clearing pass runs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_task_table_with_retry (
	input  logic                      clk,
	input  logic                      arst_n,
	ptt_in_if.sink                    evt,
	ptt_out_if.source                 res,
	input  logic                      cfg_we,
	input  logic [ptt_pkg::RET_W-1:0] cfg_wdata
);
	import ptt_pkg::*;

	cand_t            chain [TABLE_DEPTH+1];
	wr_t              wr;
	logic [CNT_W-1:0] entry_count;

	// scan enters with no candidate
	assign chain[0] = '0;

	// row of table cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		ptt_cell u_cell (
			.clk         (clk),
			.wr          (wr),
			.slot_idx    (IDX_W'(i)),
			.entry_count (entry_count),
			.cand_in     (chain[i]),
			.cand_out    (chain[i+1])
		);
	end

	// event sequencer
	ptt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt         (evt),
		.res         (res),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.scan_best   (chain[TABLE_DEPTH]),
		.wr          (wr),
		.entry_count (entry_count)
	);

endmodule

// ===== hdl/ptt_cell.sv =====
// ----------------------------------------------------------------------------
// ptt_cell
// one table entry plus one stage of the priority scan chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptt_cell (
	input  logic                       clk,
	input  ptt_pkg::wr_t               wr,
	input  logic [ptt_pkg::IDX_W-1:0]  slot_idx,
	input  logic [ptt_pkg::CNT_W-1:0]  entry_count,
	input  ptt_pkg::cand_t             cand_in,
	output ptt_pkg::cand_t             cand_out
);
	import ptt_pkg::*;

	logic [1:0]       status_q;
	logic [1:0]       prio_q;
	logic [RET_W-1:0] ret_q;
	cand_t            cand_q;
	logic             hit;
	logic             take;

	// entry update from the broadcast write
	assign hit = wr.en && (wr.slot == slot_idx);

	always_ff @(posedge clk) begin
		if (hit && wr.set_status) begin
			status_q <= wr.status;
		end
		if (hit && wr.set_prio) begin
			prio_q <= wr.prio;
		end
		if (hit && wr.set_ret) begin
			ret_q <= wr.ret;
		end
	end

	// pending entry beats the candidate only on strictly higher priority
	always_comb begin
		take = (CNT_W'(slot_idx) < entry_count) && (status_q == ST_PENDING)
			&& (!cand_in.found || (prio_q > cand_in.prio));
	end

	// hand the better candidate to the next cell
	always_ff @(posedge clk) begin
		if (take) begin
			cand_q <= '{found: 1'b1, prio: prio_q, slot: slot_idx, ret: ret_q};
		end else begin
			cand_q <= cand_in;
		end
	end

	assign cand_out = cand_q;

endmodule

// ===== hdl/ptt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptt_ctrl
// event sequencer: fill count, running task, retry limit and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "priority_task_table_with_retry_assert.svh"

module ptt_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	ptt_in_if.sink                        evt,
	ptt_out_if.source                     res,
	input  logic                          cfg_we,
	input  logic [ptt_pkg::RET_W-1:0]     cfg_wdata,
	input  ptt_pkg::cand_t                scan_best,
	output ptt_pkg::wr_t                  wr,
	output logic [ptt_pkg::CNT_W-1:0]     entry_count
);
	import ptt_pkg::*;

	state_t            state_q, state_d;
	logic [KIND_W-1:0] kind_q;
	logic [PRIO_W-1:0] prio_q;
	logic [EXIT_W-1:0] exit_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  scan_cnt_q;
	logic              run_q;
	logic [IDX_W-1:0]  run_slot_q;
	logic [RET_W-1:0]  run_ret_q;
	logic [RET_W-1:0]  max_q;
	logic              out_valid_q;
	logic [CODE_W-1:0] out_code_q;
	logic [ID_W-1:0]   out_id_q;
	logic [RET_W-1:0]  out_ret_q;

	logic              out_free;
	logic              load;
	logic [CODE_W-1:0] code_d;
	logic [ID_W-1:0]   id_d;
	logic [RET_W-1:0]  ret_d;
	logic              cnt_inc;
	logic              run_set;
	logic              run_clr;
	logic              run_ret_upd;
	logic [RET_W-1:0]  run_ret_d;
	logic              scan_done;
	logic [RET_W:0]    ret_next;
	logic [RET_W-1:0]  ret_sat;
	logic [1:0]        prio_norm;

	assign out_free    = !out_valid_q || res.ready;
	assign scan_done   = (scan_cnt_q == CNT_W'(TABLE_DEPTH));
	assign entry_count = cnt_q;

	// retry count arithmetic and priority clamp
	always_comb begin
		ret_next  = {1'b0, run_ret_q} + {{RET_W{1'b0}}, 1'b1};
		ret_sat   = ret_next[RET_W] ? {RET_W{1'b1}} : ret_next[RET_W-1:0];
		prio_norm = PRIO_LOW[1:0];
		if (prio_q == PRIO_LOW || prio_q == PRIO_MED || prio_q == PRIO_HIGH) begin
			prio_norm = prio_q[1:0];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, table writes and result
	always_comb begin
		state_d     = state_q;
		evt.ready   = 1'b0;
		load        = 1'b0;
		code_d      = RC_BUSY;
		id_d        = '0;
		ret_d       = '0;
		wr          = '0;
		cnt_inc     = 1'b0;
		run_set     = 1'b0;
		run_clr     = 1'b0;
		run_ret_upd = 1'b0;
		run_ret_d   = run_ret_q;
		unique case (state_q)
			S_IDLE: begin
				evt.ready = 1'b1;
				if (evt.valid) begin
					if (evt.kind == K_DISPATCH && !run_q) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
					unique case (kind_q)
						K_ADD: begin
							if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
								code_d = RC_FULL;
							end else begin
								code_d        = RC_ADDED;
								id_d          = make_id(cnt_q[IDX_W-1:0]);
								wr.en         = 1'b1;
								wr.slot       = cnt_q[IDX_W-1:0];
								wr.set_status = 1'b1;
								wr.status     = ST_PENDING;
								wr.set_prio   = 1'b1;
								wr.prio       = prio_norm;
								wr.set_ret    = 1'b1;
								wr.ret        = '0;
								cnt_inc       = 1'b1;
							end
						end
						K_DISPATCH: begin
							// only reached with a task running
							code_d = RC_BUSY;
							id_d   = make_id(run_slot_q);
							ret_d  = run_ret_q;
						end
						K_FINISH: begin
							if (!run_q) begin
								code_d = RC_BUSY;
							end else if (exit_q == '0) begin
								code_d        = RC_COMPLETED;
								id_d          = make_id(run_slot_q);
								ret_d         = run_ret_q;
								wr.en         = 1'b1;
								wr.slot       = run_slot_q;
								wr.set_status = 1'b1;
								wr.status     = ST_DONE;
								run_clr       = 1'b1;
							end else begin
								id_d        = make_id(run_slot_q);
								ret_d       = ret_sat;
								wr.en       = 1'b1;
								wr.slot     = run_slot_q;
								wr.set_ret  = 1'b1;
								wr.ret      = ret_sat;
								run_ret_upd = 1'b1;
								run_ret_d   = ret_sat;
								if (ret_next > {1'b0, max_q}) begin
									code_d        = RC_FAILED;
									wr.set_status = 1'b1;
									wr.status     = ST_FAILED;
									run_clr       = 1'b1;
								end else begin
									code_d = RC_RETRYING;
								end
							end
						end
						default: begin
							code_d = RC_BUSY;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (scan_done && out_free) begin
					load    = 1'b1;
					state_d = S_IDLE;
					if (scan_best.found) begin
						code_d        = RC_DISPATCHED;
						id_d          = make_id(scan_best.slot);
						ret_d         = scan_best.ret;
						wr.en         = 1'b1;
						wr.slot       = scan_best.slot;
						wr.set_status = 1'b1;
						wr.status     = ST_RUNNING;
						run_set       = 1'b1;
						run_ret_upd   = 1'b1;
						run_ret_d     = scan_best.ret;
					end else begin
						code_d = RC_NONE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// event capture
	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			kind_q <= evt.kind;
			prio_q <= evt.priority_req;
			exit_q <= evt.exit_status;
		end
	end

	// fill count, running task, scan timer and retry limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			run_q      <= 1'b0;
			run_slot_q <= '0;
			run_ret_q  <= '0;
			scan_cnt_q <= '0;
			max_q      <= MAX_RETRIES_RST;
		end else begin
			if (cnt_inc) begin
				cnt_q <= cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
			end
			if (run_set) begin
				run_q      <= 1'b1;
				run_slot_q <= scan_best.slot;
			end else if (run_clr) begin
				run_q <= 1'b0;
			end
			if (run_ret_upd) begin
				run_ret_q <= run_ret_d;
			end
			if (state_q != S_SCAN) begin
				scan_cnt_q <= '0;
			end else if (!scan_done) begin
				scan_cnt_q <= scan_cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
			end
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_code_q <= code_d;
			out_id_q   <= id_d;
			out_ret_q  <= ret_d;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.result_code  = out_code_q;
	assign res.task_id      = out_id_q;
	assign res.retries_done = out_ret_q;

	// checks
	`PTT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(TABLE_DEPTH), "fill count past depth")
	`PTT_ASSERT_NOW(a_run_in_table, run_q, CNT_W'(run_slot_q) < cnt_q, "running slot not filled")
	`PTT_ASSERT_NEXT(a_dispatch_runs, load && code_d == RC_DISPATCHED, run_q,
		"dispatch left no task running")
	`PTT_ASSERT_NEXT(a_end_stops, load && (code_d == RC_FAILED || code_d == RC_COMPLETED),
		!run_q, "ended task still running")
	`PTT_ASSERT_NOW(a_full_no_write, load && code_d == RC_FULL, !wr.en, "write on full table")

endmodule

// ===== dv/priority_task_table_with_retry_test.sv =====
// ----------------------------------------------------------------------------
// priority_task_table_with_retry_test
// self-checking bench for the priority task table: a directed table of
// events walks the corner cases, then randomized job sequences (dispatch,
// failing finishes, final finish) mixed with add bursts and stray events
// run under several max_retries settings. every result beat is compared
// field by field against its typed row or a cycle-free bench scheduler model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_task_table_with_retry_test;
	import ptt_pkg::*;

	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 205;
	localparam int DIRECTED_ROWS  = 25;
	localparam int HOLD_CYCLES    = 500;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int IDLE_PERCENT   = 18;

	localparam logic [KIND_W-1:0] K_UNKNOWN  = 2'd3;
	localparam logic [EXIT_W-1:0] EXIT_OK    = 9'h000;
	localparam logic [EXIT_W-1:0] EXIT_ABORT = 9'h1FF;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [ID_W-1:0]   id;
		logic [RET_W-1:0]  retries;
	} outcome_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PRIO_W-1:0] prio;
		logic [EXIT_W-1:0] exit_bits;
		logic              typed;
		outcome_t          want;
	} stim_row_t;

	// directed events; typed rows carry the result read straight off the spec
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{K_DISPATCH, 3'd0,      EXIT_OK,    1'b1, '{RC_NONE,       9'd0, 4'd0}},
		'{K_FINISH,   3'd0,      EXIT_OK,    1'b1, '{RC_BUSY,       9'd0, 4'd0}},
		'{K_UNKNOWN,  3'd7,      EXIT_ABORT, 1'b1, '{RC_BUSY,       9'd0, 4'd0}},
		'{K_ADD,      3'd0,      EXIT_OK,    1'b1, '{RC_ADDED,      9'd1, 4'd0}},
		'{K_ADD,      PRIO_HIGH, EXIT_OK,    1'b1, '{RC_ADDED,      9'd2, 4'd0}},
		'{K_ADD,      3'd7,      EXIT_ABORT, 1'b1, '{RC_ADDED,      9'd3, 4'd0}},
		'{K_ADD,      PRIO_MED,  EXIT_OK,    1'b1, '{RC_ADDED,      9'd4, 4'd0}},
		'{K_ADD,      3'd4,      EXIT_OK,    1'b1, '{RC_ADDED,      9'd5, 4'd0}},
		'{K_DISPATCH, 3'd7,      EXIT_ABORT, 1'b1, '{RC_DISPATCHED, 9'd2, 4'd0}},
		'{K_DISPATCH, 3'd0,      EXIT_OK,    1'b1, '{RC_BUSY,       9'd2, 4'd0}},
		'{K_FINISH,   3'd0,      EXIT_ABORT, 1'b1, '{RC_RETRYING,   9'd2, 4'd1}},
		'{K_FINISH,   3'd7,      9'h0FF,     1'b1, '{RC_RETRYING,   9'd2, 4'd2}},
		'{K_DISPATCH, 3'd0,      EXIT_OK,    1'b1, '{RC_BUSY,       9'd2, 4'd2}},
		'{K_FINISH,   3'd0,      9'h100,     1'b1, '{RC_FAILED,     9'd2, 4'd3}},
		'{K_FINISH,   3'd0,      9'h001,     1'b1, '{RC_BUSY,       9'd0, 4'd0}},
		'{K_ADD,      PRIO_HIGH, EXIT_OK,    1'b1, '{RC_ADDED,      9'd6, 4'd0}},
		'{K_DISPATCH, 3'd0,      EXIT_OK,    1'b1, '{RC_DISPATCHED, 9'd6, 4'd0}},
		'{K_FINISH,   3'd0,      EXIT_OK,    1'b1, '{RC_COMPLETED,  9'd6, 4'd0}},
		'{K_DISPATCH, 3'd0,      EXIT_OK,    1'b1, '{RC_DISPATCHED, 9'd4, 4'd0}},
		'{K_FINISH,   3'd0,      9'h0AA,     1'b0, '0},
		'{K_FINISH,   3'd0,      EXIT_OK,    1'b0, '0},
		'{K_DISPATCH, 3'd0,      EXIT_OK,    1'b1, '{RC_DISPATCHED, 9'd1, 4'd0}},
		'{K_FINISH,   3'd0,      EXIT_OK,    1'b0, '0},
		'{K_DISPATCH, 3'd0,      EXIT_OK,    1'b0, '0},
		'{K_FINISH,   3'd0,      EXIT_ABORT, 1'b0, '0}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [RET_W-1:0]  cfg_wdata;

	bit                sender_gaps  = 1'b0;
	bit                rx_gaps      = 1'b0;
	bit                hold_request = 1'b0;
	int                items_sent   = 0;
	int                mismatches   = 0;
	outcome_t          expected_results [$];

	// scheduler model state
	logic [1:0]        tbl_status  [TABLE_DEPTH];
	logic [1:0]        tbl_prio    [TABLE_DEPTH];
	logic [RET_W-1:0]  tbl_retries [TABLE_DEPTH];
	int                tbl_fill    = 0;
	int                cur_slot    = 0;
	bit                cur_active  = 1'b0;
	logic [RET_W-1:0]  retry_limit = MAX_RETRIES_RST;

	ptt_in_if  evt_if ();
	ptt_out_if res_if ();

	priority_task_table_with_retry dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// next result of the table for one event, updating the model state
	function automatic outcome_t schedule_event(input logic [KIND_W-1:0] kind,
			input logic [PRIO_W-1:0] prio, input logic [EXIT_W-1:0] exit_bits);
		outcome_t o;
		int       best;
		int       i;
		int       next_cnt;
		o.code    = RC_BUSY;
		o.id      = '0;
		o.retries = '0;
		best      = -1;
		case (kind)
			K_ADD: begin
				if (tbl_fill >= TABLE_DEPTH) begin
					o.code = RC_FULL;
				end else begin
					tbl_status[tbl_fill]  = ST_PENDING;
					tbl_prio[tbl_fill]    = (prio >= PRIO_LOW && prio <= PRIO_HIGH) ?
						prio[1:0] : PRIO_LOW[1:0];
					tbl_retries[tbl_fill] = '0;
					tbl_fill++;
					o.code = RC_ADDED;
					o.id   = tbl_fill[ID_W-1:0];
				end
			end
			K_DISPATCH: begin
				if (cur_active) begin
					o.id      = ID_W'(cur_slot + 1);
					o.retries = tbl_retries[cur_slot];
				end else begin
					// highest priority wins, strict compare keeps the lowest index
					for (i = 0; i < tbl_fill; i++)
						if (tbl_status[i] == ST_PENDING &&
								(best < 0 || tbl_prio[i] > tbl_prio[best]))
							best = i;
					if (best < 0) begin
						o.code = RC_NONE;
					end else begin
						tbl_status[best] = ST_RUNNING;
						cur_slot   = best;
						cur_active = 1'b1;
						o.code     = RC_DISPATCHED;
						o.id       = ID_W'(best + 1);
						o.retries  = tbl_retries[best];
					end
				end
			end
			K_FINISH: begin
				if (cur_active) begin
					o.id = ID_W'(cur_slot + 1);
					if (exit_bits == EXIT_OK) begin
						tbl_status[cur_slot] = ST_DONE;
						cur_active = 1'b0;
						o.code     = RC_COMPLETED;
					end else begin
						// limit check uses the unsaturated count
						next_cnt = int'(tbl_retries[cur_slot]) + 1;
						tbl_retries[cur_slot] = (next_cnt > 15) ? 4'd15 : RET_W'(next_cnt);
						if (next_cnt > int'(retry_limit)) begin
							tbl_status[cur_slot] = ST_FAILED;
							cur_active = 1'b0;
							o.code     = RC_FAILED;
						end else begin
							o.code = RC_RETRYING;
						end
					end
					o.retries = tbl_retries[cur_slot];
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic logic [PRIO_W-1:0] rand_prio();
		logic [PRIO_W-1:0] p;
		p = PRIO_W'($urandom_range(7));
		return p;
	endfunction

	function automatic logic [EXIT_W-1:0] rand_exit();
		logic [EXIT_W-1:0] e;
		e = EXIT_W'($urandom_range(511));
		return e;
	endfunction

	// nonzero exit codes, abnormal termination and the sign bit favored
	function automatic logic [EXIT_W-1:0] failing_exit();
		logic [EXIT_W-1:0] e;
		int                r;
		r = $urandom_range(99);
		if (r < 20)
			e = EXIT_ABORT;
		else if (r < 30)
			e = 9'h100;
		else
			e = EXIT_W'($urandom_range(1, 511));
		return e;
	endfunction

	// offer one event beat and queue its result once accepted
	task automatic post_event(input logic [KIND_W-1:0] kind, input logic [PRIO_W-1:0] prio,
			input logic [EXIT_W-1:0] exit_bits, input logic typed, input outcome_t want);
		outcome_t predicted;
		if (sender_gaps && $urandom_range(99) < IDLE_PERCENT) begin
			evt_if.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		evt_if.valid        <= 1'b1;
		evt_if.kind         <= kind;
		evt_if.priority_req <= prio;
		evt_if.exit_status  <= exit_bits;
		@(posedge clk);
		while (!evt_if.ready) @(posedge clk);
		predicted = schedule_event(kind, prio, exit_bits);
		expected_results.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	task automatic post_random(input logic [KIND_W-1:0] kind, input logic [PRIO_W-1:0] prio,
			input logic [EXIT_W-1:0] exit_bits);
		post_event(kind, prio, exit_bits, 1'b0, '0);
	endtask

	// dispatch, a run of failing exits, then usually a clean exit
	task automatic run_job();
		int fails;
		int n;
		if ($urandom_range(3) == 0)
			fails = int'(retry_limit) + 1;
		else
			fails = $urandom_range(int'(retry_limit) + 2);
		post_random(K_DISPATCH, rand_prio(), rand_exit());
		for (n = 0; n < fails; n++) begin
			if ($urandom_range(9) == 0)
				post_random(K_DISPATCH, rand_prio(), rand_exit());
			post_random(K_FINISH, rand_prio(), failing_exit());
		end
		if ($urandom_range(3) != 0)
			post_random(K_FINISH, rand_prio(), EXIT_OK);
	endtask

	// stop offering and wait for every outstanding result
	task automatic settle();
		evt_if.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_retry_limit(input logic [RET_W-1:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		retry_limit = value;
	endtask

	// result sink: random backpressure plus one long hold-off on request
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				res_if.ready <= rx_gaps ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
			end
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: expected no beat, got code %0d id %0d retries %0d",
					$time, res_if.result_code, res_if.task_id, res_if.retries_done);
			end else begin
				want = expected_results.pop_front();
				if (res_if.result_code !== want.code || res_if.task_id !== want.id ||
						res_if.retries_done !== want.retries) begin
					mismatches++;
					$display("%0t: expected code/id/retries %0d/%0d/%0d, got %0d/%0d/%0d",
						$time, want.code, want.id, want.retries,
						res_if.result_code, res_if.task_id, res_if.retries_done);
				end
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (evt_if.valid === 1'b1 && evt_if.ready === 1'b1) ||
					(res_if.valid === 1'b1 && res_if.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// stimulus sequence
	initial begin
		logic [RET_W-1:0] limit_plan [RANDOM_PHASES];
		int               p;
		int               r;
		int               phase_start;
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= '0;
		evt_if.valid        <= 1'b0;
		evt_if.kind         <= K_ADD;
		evt_if.priority_req <= '0;
		evt_if.exit_status  <= '0;
		limit_plan = '{4'd0, 4'd15, 4'd1, 4'd7, 4'd15, 4'd0, 4'd3, 4'd0};
		limit_plan[RANDOM_PHASES-1] = RET_W'($urandom_range(15));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, run with the reset retry limit
		sender_gaps = 1'b1;
		rx_gaps     = 1'b1;
		for (r = 0; r < DIRECTED_ROWS; r++)
			post_event(directed_rows[r].kind, directed_rows[r].prio,
				directed_rows[r].exit_bits, directed_rows[r].typed, directed_rows[r].want);

		// random phases, one retry limit each; first phase runs without idling
		for (p = 0; p < RANDOM_PHASES; p++) begin
			set_retry_limit(limit_plan[p]);
			sender_gaps = (p != 0);
			rx_gaps     = (p != 0);
			if (p == 2)
				hold_request = 1'b1;
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 40) begin
					repeat ($urandom_range(1, 4)) post_random(K_ADD, rand_prio(), rand_exit());
				end else if (r < 52) begin
					case ($urandom_range(2))
						0: post_random(K_UNKNOWN, rand_prio(), rand_exit());
						1: post_random(K_DISPATCH, rand_prio(), rand_exit());
						default: post_random(K_FINISH, rand_prio(), rand_exit());
					endcase
				end else begin
					run_job();
				end
			end
		end

		// drain, then allow one full scan for stray beats
		settle();
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ptt_pkg.sv
hdl/ptt_in_if.sv
hdl/ptt_out_if.sv
hdl/ptt_cell.sv
hdl/ptt_ctrl.sv
hdl/priority_task_table_with_retry.sv
dv/priority_task_table_with_retry_test.sv
